// File: sv/mt19937_keystream_cipher_defines.svh
// Assertion macros used by the keystream cipher datapath.
`ifndef MT19937_KEYSTREAM_CIPHER_DEFINES_SVH
`define MT19937_KEYSTREAM_CIPHER_DEFINES_SVH

`ifndef SYNTHESIS
`define MTKC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MTKC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MTKC_ASSERT_IMP(label, ante, cons, msg)
`define MTKC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: sv/mtkc_pkg.sv
// Types, constants and microcode table of the keystream cipher.
package mtkc_pkg;

    localparam int STATE_WORDS = 624;
    localparam int WORD_W      = 32;
    localparam int ADDR_W      = $clog2(STATE_WORDS);
    localparam int SHIFT_DIST  = 397;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [WORD_W-1:0] word_t;

    localparam addr_t LAST_IDX   = addr_t'(STATE_WORDS - 1);
    localparam addr_t FAR_OFFSET = addr_t'(SHIFT_DIST);
    localparam addr_t FAR_WRAP   = addr_t'(STATE_WORDS - SHIFT_DIST);

    localparam word_t SEED_RESET = 32'd5489;
    localparam word_t INIT_MULT  = 32'd1812433253;
    localparam word_t TWIST_XOR  = 32'h9908b0df;
    localparam word_t TEMPER_B   = 32'h9d2c5680;
    localparam word_t TEMPER_C   = 32'hefc60000;

    localparam logic [1:0] KIND_RESTART = 2'd0;
    localparam logic [1:0] KIND_BYTE    = 2'd1;
    localparam logic [1:0] KIND_WORD    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_STORE,
        ST_MUL,
        ST_RDCUR,
        ST_RD2,
        ST_TWIST,
        ST_BYTEOUT
    } step_t;

    typedef enum logic [2:0] {
        UOP_IDLE,
        UOP_SEED,
        UOP_STORE,
        UOP_MUL,
        UOP_RDCUR,
        UOP_RD2,
        UOP_TWIST,
        UOP_BYTEOUT
    } uop_t;

    typedef enum logic [1:0] {
        C_NEXT,
        C_ALWAYS,
        C_DISPATCH,
        C_INIT_LAST
    } cond_t;

    typedef struct packed {
        uop_t  op;
        cond_t cond;
        step_t target;
    } ucode_t;

    typedef struct packed {
        logic byte_mid;
        logic cached;
        logic init_last;
        logic stall;
    } seq_status_t;

    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t u;
        case (s)
            ST_IDLE:    u = '{op: UOP_IDLE,    cond: C_DISPATCH,  target: ST_IDLE};
            ST_SEED:    u = '{op: UOP_SEED,    cond: C_ALWAYS,    target: ST_MUL};
            ST_STORE:   u = '{op: UOP_STORE,   cond: C_INIT_LAST, target: ST_IDLE};
            ST_MUL:     u = '{op: UOP_MUL,     cond: C_ALWAYS,    target: ST_STORE};
            ST_RDCUR:   u = '{op: UOP_RDCUR,   cond: C_NEXT,      target: ST_RD2};
            ST_RD2:     u = '{op: UOP_RD2,     cond: C_NEXT,      target: ST_TWIST};
            ST_TWIST:   u = '{op: UOP_TWIST,   cond: C_ALWAYS,    target: ST_IDLE};
            ST_BYTEOUT: u = '{op: UOP_BYTEOUT, cond: C_ALWAYS,    target: ST_IDLE};
            default:    u = '{op: UOP_IDLE,    cond: C_DISPATCH,  target: ST_IDLE};
        endcase
        return u;
    endfunction

endpackage

// File: sv/mt19937_keystream_cipher.sv
// Top level of the MT19937 keystream cipher.
//
//  channel | signals                          | handshake
//  --------+----------------------------------+---------------------------
//  input   | kind, data_byte                  | in_valid / in_ready
//  output  | value, is_word                   | out_valid / out_ready
//  config  | cfg_wdata                        | cfg_we, no wait
//
// Restart: a seed step, then a multiply step and a store step per further state word.
// Word draw: RD2 and twist steps, with an RDCUR step first on the first draw after
// restart (cold neighbor cache), since the two-port state RAM read is registered.
// Byte draw: the byte-out step within a word, otherwise as a word draw.
// Reset leaves the state RAM unwritten; a restart must come before any draw.
// A full output register with out_ready low holds the emitting step.
module mt19937_keystream_cipher
    import mtkc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] value,
    output logic        is_word,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    ucode_t      ctrl;
    seq_status_t status;
    logic        ram_we;
    addr_t       ram_waddr;
    word_t       ram_wdata;
    logic        ram_re_a;
    addr_t       ram_raddr_a;
    word_t       ram_rdata_a;
    logic        ram_re_b;
    addr_t       ram_raddr_b;
    word_t       ram_rdata_b;

    mtkc_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .status   (status),
        .ctrl     (ctrl),
        .in_ready (in_ready)
    );

    mtkc_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .in_valid    (in_valid),
        .kind        (kind),
        .data_byte   (data_byte),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .value       (value),
        .is_word     (is_word),
        .status      (status),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re_a    (ram_re_a),
        .ram_raddr_a (ram_raddr_a),
        .ram_rdata_a (ram_rdata_a),
        .ram_re_b    (ram_re_b),
        .ram_raddr_b (ram_raddr_b),
        .ram_rdata_b (ram_rdata_b)
    );

    mtkc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STATE_WORDS)
    ) u_state_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re_a    (ram_re_a),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .re_b    (ram_re_b),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

endmodule

// File: sv/mtkc_ram.sv
// Generic RAM: one write port, two registered read ports.
module mtkc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re_a,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic             re_b,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re_a)
        begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b)
        begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// File: sv/mtkc_seq.sv
// Microcode sequencer: step counter, control store and jump logic.
module mtkc_seq
    import mtkc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [1:0]  kind,
    input  seq_status_t status,
    output ucode_t      ctrl,
    output logic        in_ready
);

    step_t upc_reg;
    step_t upc_next;
    step_t upc_inc;
    logic  in_fire;
    step_t draw_step;

    assign ctrl      = ucode_rom(upc_reg);
    assign in_ready  = (ctrl.op == UOP_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign upc_inc   = step_t'(3'(upc_reg + 3'd1));
    assign draw_step = status.cached ? ST_RD2 : ST_RDCUR;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= ST_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    always_comb
    begin
        upc_next = ST_IDLE;
        case (ctrl.cond)
            C_NEXT:      upc_next = upc_inc;
            C_ALWAYS:    upc_next = ctrl.target;
            C_INIT_LAST: upc_next = status.init_last ? ctrl.target : upc_inc;
            C_DISPATCH:
            begin
                if (in_fire)
                begin
                    case (kind)
                        KIND_RESTART: upc_next = ST_SEED;
                        KIND_BYTE:    upc_next = status.byte_mid ? ST_BYTEOUT : draw_step;
                        KIND_WORD:    upc_next = draw_step;
                        default:      upc_next = ST_IDLE;
                    endcase
                end
            end
            default:     upc_next = ST_IDLE;
        endcase
        if (status.stall)
        begin
            upc_next = upc_reg;
        end
    end

endmodule

// File: sv/mtkc_datapath.sv
// Datapath: seeding, on-the-fly twist, tempering and output register.
`include "mt19937_keystream_cipher_defines.svh"

module mtkc_datapath
    import mtkc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ucode_t      ctrl,
    input  logic        in_valid,
    input  logic [1:0]  kind,
    input  logic [7:0]  data_byte,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [31:0] value,
    output logic        is_word,
    output seq_status_t status,
    output logic        ram_we,
    output addr_t       ram_waddr,
    output word_t       ram_wdata,
    output logic        ram_re_a,
    output addr_t       ram_raddr_a,
    input  word_t       ram_rdata_a,
    output logic        ram_re_b,
    output addr_t       ram_raddr_b,
    input  word_t       ram_rdata_b
);

    function automatic word_t temper(input word_t x);
        word_t t;
        t = x ^ (x >> 11);
        t = t ^ ((t << 7) & TEMPER_B);
        t = t ^ ((t << 15) & TEMPER_C);
        t = t ^ (t >> 18);
        return t;
    endfunction

    word_t       seed_reg, seed_next;
    addr_t       idx_reg, idx_next;
    addr_t       k_reg, k_next;
    logic        cache_valid_reg, cache_valid_next;
    logic [1:0]  bytepos_reg, bytepos_next;
    word_t       cur_reg, cur_next;
    logic        out_valid_reg, out_valid_next;
    word_t       p_reg, p_next;
    word_t       prod_reg, prod_next;
    word_t       cache_reg, cache_next;
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  data_reg, data_next;
    word_t       value_reg, value_next;
    logic        is_word_reg, is_word_next;

    logic        in_fire;
    logic        stall;
    addr_t       nb_addr;
    addr_t       far_addr;
    word_t       mix;
    word_t       init_word;
    word_t       y;
    word_t       twisted;
    word_t       tempered;
    logic [7:0]  ks_byte;

    assign in_fire   = in_valid && (ctrl.op == UOP_IDLE);
    assign stall     = ((ctrl.op == UOP_TWIST) || (ctrl.op == UOP_BYTEOUT))
                       && out_valid_reg && !out_ready;
    assign nb_addr   = (idx_reg == LAST_IDX) ? '0 : idx_reg + addr_t'(1);
    assign far_addr  = (idx_reg < FAR_WRAP) ? idx_reg + FAR_OFFSET : idx_reg - FAR_WRAP;
    assign mix       = p_reg ^ (p_reg >> 30);
    assign init_word = prod_reg + word_t'(k_reg);
    assign y         = {cache_reg[WORD_W-1], ram_rdata_a[WORD_W-2:0]};
    assign twisted   = ram_rdata_b ^ (y >> 1) ^ (y[0] ? TWIST_XOR : '0);
    assign tempered  = temper(twisted);
    assign ks_byte   = cur_reg[{bytepos_reg, 3'b000} +: 8];

    assign status.byte_mid  = (bytepos_reg != 2'd0);
    assign status.cached    = cache_valid_reg;
    assign status.init_last = (k_reg == LAST_IDX);
    assign status.stall     = stall;

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign is_word   = is_word_reg;

    always_comb
    begin
        seed_next        = cfg_we ? cfg_wdata : seed_reg;
        idx_next         = idx_reg;
        k_next           = k_reg;
        cache_valid_next = cache_valid_reg;
        bytepos_next     = bytepos_reg;
        cur_next         = cur_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        p_next           = p_reg;
        prod_next        = prod_reg;
        cache_next       = cache_reg;
        kind_next        = kind_reg;
        data_next        = data_reg;
        value_next       = value_reg;
        is_word_next     = is_word_reg;
        ram_we           = 1'b0;
        ram_waddr        = idx_reg;
        ram_wdata        = twisted;
        ram_re_a         = 1'b0;
        ram_raddr_a      = idx_reg;
        ram_re_b         = 1'b0;
        ram_raddr_b      = far_addr;
        case (ctrl.op)
            UOP_IDLE:
            begin
                if (in_fire)
                begin
                    kind_next = kind;
                    data_next = data_byte;
                end
            end
            UOP_SEED:
            begin
                ram_we           = 1'b1;
                ram_waddr        = '0;
                ram_wdata        = seed_reg;
                p_next           = seed_reg;
                k_next           = addr_t'(1);
                idx_next         = '0;
                cache_valid_next = 1'b0;
                bytepos_next     = 2'd0;
                cur_next         = '0;
            end
            UOP_MUL:
            begin
                prod_next = INIT_MULT * mix;
            end
            UOP_STORE:
            begin
                ram_we    = 1'b1;
                ram_waddr = k_reg;
                ram_wdata = init_word;
                p_next    = init_word;
                k_next    = k_reg + addr_t'(1);
            end
            UOP_RDCUR:
            begin
                ram_re_a    = 1'b1;
                ram_raddr_a = idx_reg;
            end
            UOP_RD2:
            begin
                ram_re_a    = 1'b1;
                ram_raddr_a = nb_addr;
                ram_re_b    = 1'b1;
                ram_raddr_b = far_addr;
                if (!cache_valid_reg)
                begin
                    cache_next = ram_rdata_a;
                end
            end
            UOP_TWIST:
            begin
                if (!stall)
                begin
                    ram_we           = 1'b1;
                    ram_waddr        = idx_reg;
                    ram_wdata        = twisted;
                    cache_next       = ram_rdata_a;
                    cache_valid_next = 1'b1;
                    idx_next         = nb_addr;
                    out_valid_next   = 1'b1;
                    if (kind_reg == KIND_WORD)
                    begin
                        value_next   = tempered;
                        is_word_next = 1'b1;
                    end
                    else
                    begin
                        value_next   = {{(WORD_W-8){1'b0}}, tempered[7:0] ^ data_reg};
                        is_word_next = 1'b0;
                        cur_next     = tempered;
                        bytepos_next = 2'd1;
                    end
                end
            end
            UOP_BYTEOUT:
            begin
                if (!stall)
                begin
                    value_next     = {{(WORD_W-8){1'b0}}, ks_byte ^ data_reg};
                    is_word_next   = 1'b0;
                    bytepos_next   = bytepos_reg + 2'd1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg        <= SEED_RESET;
            idx_reg         <= '0;
            k_reg           <= '0;
            cache_valid_reg <= 1'b0;
            bytepos_reg     <= 2'd0;
            cur_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            seed_reg        <= seed_next;
            idx_reg         <= idx_next;
            k_reg           <= k_next;
            cache_valid_reg <= cache_valid_next;
            bytepos_reg     <= bytepos_next;
            cur_reg         <= cur_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg       <= p_next;
        prod_reg    <= prod_next;
        cache_reg   <= cache_next;
        kind_reg    <= kind_next;
        data_reg    <= data_next;
        value_reg   <= value_next;
        is_word_reg <= is_word_next;
    end

    `MTKC_ASSERT_NEXT(a_twist_emits, (ctrl.op == UOP_TWIST) && !stall, out_valid_reg && cache_valid_reg, "twist step did not post a beat")
    `MTKC_ASSERT_IMP(a_ram_no_rw, ram_we, !(ram_re_a || ram_re_b), "ram write overlaps a read")
    `MTKC_ASSERT_IMP(a_store_index, ctrl.op == UOP_STORE, (k_reg != '0) && (k_reg <= LAST_IDX), "seed store index out of range")
    `MTKC_ASSERT_NEXT(a_stall_holds, stall, (value_reg == $past(value_reg)) && out_valid_reg, "stalled beat changed")

endmodule

// File: tb/tb.sv
// Self-checking testbench for mt19937_keystream_cipher: directed table, then random beats.
module tb
    import mtkc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 1400;
    localparam int SCRIPT_ROWS   = 22;

    typedef struct packed {
        word_t value;
        logic  is_word;
    } cipher_out_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       typed;
        word_t      value;
        logic       is_word;
    } script_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [1:0]  kind      = KIND_RESTART;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] value;
    logic        is_word;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = 32'h0;

    word_t       seed_reg = SEED_RESET;
    word_t       twister [STATE_WORDS];
    int          word_ptr = STATE_WORDS;
    logic [1:0]  byte_ptr = 2'd0;
    word_t       cur_word = 32'h0;
    cipher_out_t keystream_q [$];

    int errors        = 0;
    int cycles        = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Typed values follow from the default seed: first tempered word 0xd091bb5c.
    script_row_t script [SCRIPT_ROWS] = '{
        '{KIND_RESTART, 8'h00, 1'b0, 32'h0,        1'b0},
        '{KIND_WORD,    8'hff, 1'b1, 32'hd091bb5c, 1'b1},
        '{KIND_RESTART, 8'hff, 1'b0, 32'h0,        1'b0},
        '{KIND_BYTE,    8'h00, 1'b1, 32'h0000005c, 1'b0},
        '{KIND_BYTE,    8'hff, 1'b1, 32'h00000044, 1'b0},
        '{KIND_BYTE,    8'h00, 1'b1, 32'h00000091, 1'b0},
        '{KIND_BYTE,    8'hff, 1'b1, 32'h0000002f, 1'b0},
        '{KIND_BYTE,    8'h5a, 1'b0, 32'h0,        1'b0},
        '{KIND_WORD,    8'h00, 1'b0, 32'h0,        1'b0},
        '{KIND_BYTE,    8'ha5, 1'b0, 32'h0,        1'b0},
        '{KIND_UNUSED,  8'hff, 1'b0, 32'h0,        1'b0},
        '{KIND_BYTE,    8'h3c, 1'b0, 32'h0,        1'b0},
        '{KIND_UNUSED,  8'h00, 1'b0, 32'h0,        1'b0},
        '{KIND_RESTART, 8'h00, 1'b0, 32'h0,        1'b0},
        '{KIND_BYTE,    8'h00, 1'b1, 32'h0000005c, 1'b0},
        '{KIND_WORD,    8'h00, 1'b0, 32'h0,        1'b0},
        '{KIND_BYTE,    8'h80, 1'b0, 32'h0,        1'b0},
        '{KIND_RESTART, 8'h00, 1'b0, 32'h0,        1'b0},
        '{KIND_RESTART, 8'hff, 1'b0, 32'h0,        1'b0},
        '{KIND_WORD,    8'h00, 1'b1, 32'hd091bb5c, 1'b1},
        '{KIND_BYTE,    8'h01, 1'b0, 32'h0,        1'b0},
        '{KIND_BYTE,    8'h7f, 1'b0, 32'h0,        1'b0}
    };

    mt19937_keystream_cipher uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .is_word   (is_word),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    function automatic void reseed_state();
        twister[0] = seed_reg;
        for (int k = 1; k < STATE_WORDS; k++)
        begin
            twister[k] = INIT_MULT * (twister[k-1] ^ (twister[k-1] >> 30)) + word_t'(k);
        end
        word_ptr = STATE_WORDS;
        byte_ptr = 2'd0;
        cur_word = 32'h0;
    endfunction

    function automatic void regenerate_state();
        word_t y;
        word_t w;
        int    nb;
        int    far;
        for (int k = 0; k < STATE_WORDS; k++)
        begin
            nb  = (k + 1) % STATE_WORDS;
            far = (k + SHIFT_DIST) % STATE_WORDS;
            y   = (twister[k] & 32'h80000000) | (twister[nb] & 32'h7fffffff);
            w   = twister[far] ^ (y >> 1);
            if (y[0])
            begin
                w = w ^ TWIST_XOR;
            end
            twister[k] = w;
        end
        word_ptr = 0;
    endfunction

    function automatic word_t draw_tempered();
        word_t y;
        if (word_ptr >= STATE_WORDS)
        begin
            regenerate_state();
        end
        y = twister[word_ptr];
        word_ptr++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic logic predict_beat(input logic [1:0] k, input logic [7:0] d,
                                          output cipher_out_t r);
        logic [7:0] ks;
        logic       has_out;
        r       = '0;
        has_out = 1'b0;
        case (k)
            KIND_RESTART:
            begin
                reseed_state();
            end
            KIND_BYTE:
            begin
                if (byte_ptr == 2'd0)
                begin
                    cur_word = draw_tempered();
                end
                ks       = 8'(cur_word >> (8 * byte_ptr));
                byte_ptr = byte_ptr + 2'd1;
                r        = '{value: {24'h0, ks ^ d}, is_word: 1'b0};
                has_out  = 1'b1;
            end
            KIND_WORD:
            begin
                r       = '{value: draw_tempered(), is_word: 1'b1};
                has_out = 1'b1;
            end
            default:
            begin
                has_out = 1'b0;
            end
        endcase
        return has_out;
    endfunction

    task automatic flag_mismatch(input string what, input word_t got, input word_t want);
        errors++;
        $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    task automatic send_beat(input logic [1:0] k, input logic [7:0] d,
                             input logic typed, input cipher_out_t typed_out);
        cipher_out_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        data_byte <= d;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        if (predict_beat(k, d, r))
        begin
            keystream_q.push_back(typed ? typed_out : r);
        end
    endtask

    // Hold the sender until every result is back, then let the block settle.
    task automatic wait_idle(input int hold);
        in_valid <= 1'b0;
        @(posedge clk);
        while (keystream_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (hold) @(posedge clk);
    endtask

    task automatic write_seed(input word_t v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        seed_reg  = v;
    endtask

    task automatic run_phase(input int phase, input int count);
        logic [1:0] k;
        logic [7:0] d;
        int         r;
        send_beat(KIND_RESTART, 8'($urandom), 1'b0, '0);
        for (int i = 1; i < count; i++)
        begin
            if (phase == 1 && i == 250)
            begin
                wait_idle(0);
            end
            r = $urandom_range(99);
            d = 8'($urandom);
            // Mostly words in the first phase so the generator runs through a twist.
            if (phase == 0)
            begin
                k = (r < 88) ? KIND_WORD : (r < 98) ? KIND_BYTE : KIND_UNUSED;
            end
            else
            begin
                k = (r < 3) ? KIND_RESTART : (r < 5) ? KIND_UNUSED :
                    (r < 50) ? KIND_WORD : KIND_BYTE;
            end
            send_beat(k, d, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        cipher_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (keystream_q.size() == 0)
            begin
                flag_mismatch("result with no expectation", value, 32'h0);
            end
            else
            begin
                want = keystream_q.pop_front();
                if (value !== want.value)
                begin
                    flag_mismatch("value", value, want.value);
                end
                if (is_word !== want.is_word)
                begin
                    flag_mismatch("is_word", 32'(is_word), 32'(want.is_word));
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        script_row_t row;
        cipher_out_t typed_out;
        send_idle_pct = 16;
        recv_idle_pct = 65;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < SCRIPT_ROWS; i++)
        begin
            row       = script[i];
            typed_out = '{value: row.value, is_word: row.is_word};
            send_beat(row.kind, row.data, row.typed, typed_out);
        end

        wait_idle(SETTLE_CYCLES);
        write_seed(32'hffffffff);
        run_phase(0, 760);

        wait_idle(SETTLE_CYCLES);
        send_idle_pct = 65;
        recv_idle_pct = 16;
        write_seed(32'h00000000);
        run_phase(1, 570);

        wait_idle(SETTLE_CYCLES);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_seed($urandom);
        run_phase(2, 570);

        wait_idle(SETTLE_CYCLES);
        if (errors == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
